// ----- rtl/tsl_pkg.sv -----
package tsl_pkg;

  localparam int TIME_W     = 48;
  localparam int BEAT_W     = 48;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int UNIT_W     = 17;

  localparam logic [UNIT_W-1:0] UNIT_ONE = 17'h10000;

  // waveform codes
  localparam logic [2:0] WAVE_COSINE    = 3'd0;
  localparam logic [2:0] WAVE_TRIANGLE  = 3'd1;
  localparam logic [2:0] WAVE_RAMP_UP   = 3'd2;
  localparam logic [2:0] WAVE_RAMP_DOWN = 3'd3;
  localparam logic [2:0] WAVE_SQUARE    = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIPOLAR      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BEATS        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET       = 3'd6;

  typedef struct packed {
    logic [2:0]         waveform;
    logic               bipolar;
    logic signed [23:0] depth;
    logic signed [23:0] centre;
    logic [31:0]        rate;
    logic [31:0]        beats;
    logic [23:0]        offset;
  } cfg_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // sin^2(pi*k/n) in q.16, only evaluated on constants to fill the table
  function automatic logic [UNIT_W-1:0] sine_sq_entry(input int unsigned k,
                                                      input int unsigned bits);
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] u;
    n  = 64'd1 << bits;
    m  = (64'(k) > (n >> 1)) ? n - 64'(k) : 64'(k);
    th = (PI_Q30 * m) >> bits;
    t2 = (th * th) >> 30;
    a  = Q30_ONE - t2 / 64'd110;
    a  = Q30_ONE - ((t2 * a) >> 30) / 64'd72;
    a  = Q30_ONE - ((t2 * a) >> 30) / 64'd42;
    a  = Q30_ONE - ((t2 * a) >> 30) / 64'd20;
    a  = Q30_ONE - ((t2 * a) >> 30) / 64'd6;
    s  = (th * a) >> 30;
    u  = (s * s + (64'd1 << 43)) >> 44;
    return (u > 64'(UNIT_ONE)) ? UNIT_ONE : u[UNIT_W-1:0];
  endfunction

endpackage

// ----- rtl/tsl_if.sv -----
interface tsl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [tsl_pkg::TIME_W-1:0]           time_stamp;
  logic signed [tsl_pkg::BEAT_W-1:0]    beat_pos;

  modport source(output valid, time_stamp, beat_pos, input ready);
  modport sink(input valid, time_stamp, beat_pos, output ready);
endinterface

interface tsl_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tsl_pkg::OUT_W-1:0]   lfo_out;
  logic                               saturated;

  modport source(output valid, lfo_out, saturated, input ready);
  modport sink(input valid, lfo_out, saturated, output ready);
endinterface

// ----- rtl/tempo_synced_lfo.sv -----
// tempo synced lfo: one modulation value for each input transfer
// in_i carries time_stamp (unsigned q32.16 s) and beat_pos (signed
// q32.16 beats); out_o carries lfo_out (signed q.16) and saturated
// registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the
// user must write them only while no item is in flight, which the block
// does not enforce; indexes 0..6 are waveform, bipolar_mode, depth,
// centre, rate, beats_per_cycle, phase offset
// the remainder and fraction pipelines resolve one bit per stage over
// 48 dividend bits and PHASE_BITS quotient bits
// throughput is one transfer per cycle; every stage carries a valid bit
// when the receiver stalls with a result waiting, the whole pipeline
// holds and in_i.ready drops; nothing is lost or repeated
// reset empties the pipeline and loads the register defaults:
// raised cosine, unipolar, depth 1.0, centre 0.5, rate 1 hz, free running
module tempo_synced_lfo #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tsl_in_if.sink                              in_i,
  tsl_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [tsl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tsl_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  tsl_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.waveform <= tsl_pkg::WAVE_COSINE;
      cfg_q.bipolar  <= 1'b0;
      cfg_q.depth    <= 24'sd65536;
      cfg_q.centre   <= 24'sd32768;
      cfg_q.rate     <= 32'd65536;
      cfg_q.beats    <= '0;
      cfg_q.offset   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsl_pkg::REG_WAVEFORM:     cfg_q.waveform <= cfg_data_i[2:0];
        tsl_pkg::REG_BIPOLAR:      cfg_q.bipolar  <= cfg_data_i[0];
        tsl_pkg::REG_DEPTH:        cfg_q.depth    <= cfg_data_i[23:0];
        tsl_pkg::REG_CENTRE:       cfg_q.centre   <= cfg_data_i[23:0];
        tsl_pkg::REG_RATE:         cfg_q.rate     <= cfg_data_i;
        tsl_pkg::REG_BEATS:        cfg_q.beats    <= cfg_data_i;
        tsl_pkg::REG_OFFSET:       cfg_q.offset   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a result is waiting on a stalled receiver
  logic adv;
  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  logic                   ph_valid;
  logic [PHASE_BITS-1:0]  ph;
  logic                   un_valid;
  logic [tsl_pkg::UNIT_W-1:0] un;

  tsl_phase #(
    .PHASE_BITS(PHASE_BITS)
  ) u_phase (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .cfg_i          (cfg_q),
    .valid_i        (in_i.valid),
    .time_stamp_i   (in_i.time_stamp),
    .beat_pos_i     (in_i.beat_pos),
    .valid_o        (ph_valid),
    .phase_o        (ph)
  );

  tsl_shape #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_shape (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cfg_i  (cfg_q),
    .valid_i(ph_valid),
    .phase_i(ph),
    .valid_o(un_valid),
    .unit_o (un)
  );

  tsl_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .cfg_i      (cfg_q),
    .valid_i    (un_valid),
    .unit_i     (un),
    .valid_o    (out_o.valid),
    .lfo_out_o  (out_o.lfo_out),
    .saturated_o(out_o.saturated)
  );

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while output stalled");

  a_depth_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == tsl_pkg::REG_DEPTH |=> cfg_q.depth == $past(cfg_data_i[23:0]))
    else $error("depth register write lost");

endmodule

// ----- rtl/tsl_phase.sv -----
module tsl_phase #(
  parameter int PHASE_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  tsl_pkg::cfg_t                     cfg_i,
  input  logic                              valid_i,
  input  logic [tsl_pkg::TIME_W-1:0]        time_stamp_i,
  input  logic signed [tsl_pkg::BEAT_W-1:0] beat_pos_i,
  output logic                              valid_o,
  output logic [PHASE_BITS-1:0]             phase_o
);

  localparam int DIV_N = tsl_pkg::BEAT_W;

  // remainder pipeline: one dividend bit per stage
  logic                    dv_q   [DIV_N+1];
  logic [31:0]             drem_q [DIV_N+1];
  logic [DIV_N-1:0]        dmag_q [DIV_N+1];
  logic                    dneg_q [DIV_N+1];
  logic [PHASE_BITS-1:0]   dfree_q[DIV_N+1];

  logic [31:0]             prod_lo;
  logic [DIV_N-1:0]        bmag;

  assign prod_lo = 32'(time_stamp_i[31:0] * cfg_i.rate);
  assign bmag    = beat_pos_i[DIV_N-1] ? DIV_N'(-beat_pos_i)
                                       : DIV_N'(beat_pos_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv_i) begin
      dv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      drem_q[0]  <= '0;
      dmag_q[0]  <= bmag;
      dneg_q[0]  <= beat_pos_i[DIV_N-1];
      dfree_q[0] <= prod_lo[31 -: PHASE_BITS];
    end
  end

  for (genvar j = 0; j < DIV_N; j++) begin : g_rem
    logic [32:0] sh;
    logic        ge;
    assign sh = {drem_q[j], dmag_q[j][DIV_N-1]};
    assign ge = sh >= {1'b0, cfg_i.beats};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (adv_i) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        drem_q[j+1]  <= ge ? 32'(sh - {1'b0, cfg_i.beats}) : sh[31:0];
        dmag_q[j+1]  <= {dmag_q[j][DIV_N-2:0], 1'b0};
        dneg_q[j+1]  <= dneg_q[j];
        dfree_q[j+1] <= dfree_q[j];
      end
    end
  end

  // floor remainder: fold a negative dividend back into 0..beats-1
  logic                  cv_q;
  logic [31:0]           cr_q;
  logic [PHASE_BITS-1:0] cfree_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= 1'b0;
    end else if (adv_i) begin
      cv_q <= dv_q[DIV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cr_q    <= (dneg_q[DIV_N] && drem_q[DIV_N] != '0) ?
                 cfg_i.beats - drem_q[DIV_N] : drem_q[DIV_N];
      cfree_q <= dfree_q[DIV_N];
    end
  end

  // fraction pipeline: one quotient bit of r * 2^PHASE_BITS / beats per stage
  logic                  fv_q   [PHASE_BITS+1];
  logic [31:0]           frem_q [PHASE_BITS+1];
  logic [PHASE_BITS-1:0] fq_q   [PHASE_BITS+1];
  logic [PHASE_BITS-1:0] ffree_q[PHASE_BITS+1];

  assign fv_q[0]    = cv_q;
  assign frem_q[0]  = cr_q;
  assign fq_q[0]    = '0;
  assign ffree_q[0] = cfree_q;

  for (genvar j = 0; j < PHASE_BITS; j++) begin : g_frac
    logic [32:0] sh;
    logic        ge;
    assign sh = {frem_q[j], 1'b0};
    assign ge = sh >= {1'b0, cfg_i.beats};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fv_q[j+1] <= 1'b0;
      end else if (adv_i) begin
        fv_q[j+1] <= fv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        frem_q[j+1]  <= ge ? 32'(sh - {1'b0, cfg_i.beats}) : sh[31:0];
        fq_q[j+1]    <= {fq_q[j][PHASE_BITS-2:0], ge};
        ffree_q[j+1] <= ffree_q[j];
      end
    end
  end

  logic [PHASE_BITS-1:0] off;
  logic [PHASE_BITS-1:0] frac;

  if (PHASE_BITS >= 24) begin : g_off_up
    assign off = PHASE_BITS'(cfg_i.offset) << (PHASE_BITS - 24);
  end else begin : g_off_dn
    assign off = PHASE_BITS'(cfg_i.offset >> (24 - PHASE_BITS));
  end

  assign frac = (cfg_i.beats != '0) ? fq_q[PHASE_BITS] : ffree_q[PHASE_BITS];

  logic                  pv_q;
  logic [PHASE_BITS-1:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (adv_i) begin
      pv_q <= fv_q[PHASE_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_q <= frac + off;
    end
  end

  assign valid_o = pv_q;
  assign phase_o = p_q;

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_q && cfg_i.beats != '0 |-> cr_q < cfg_i.beats)
    else $error("beat remainder out of range");

endmodule

// ----- rtl/tsl_shape.sv -----
module tsl_shape #(
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  tsl_pkg::cfg_t                cfg_i,
  input  logic                         valid_i,
  input  logic [PHASE_BITS-1:0]        phase_i,
  output logic                         valid_o,
  output logic [tsl_pkg::UNIT_W-1:0]   unit_o
);

  localparam int UW = tsl_pkg::UNIT_W;
  localparam int N  = 1 << SINE_TABLE_BITS;
  localparam int FB = PHASE_BITS - SINE_TABLE_BITS;
  localparam int SH = PHASE_BITS - 16;

  logic [UW-1:0] rom [N];

  for (genvar k = 0; k < N; k++) begin : g_rom
    localparam logic [UW-1:0] ENTRY = tsl_pkg::sine_sq_entry(k, SINE_TABLE_BITS);
    assign rom[k] = ENTRY;
  end

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS-1:0] idx_n;
  logic [PHASE_BITS+1:0]      tri_w;
  logic [PHASE_BITS:0]        down_w;
  logic [UW-1:0]              u_other;

  assign idx    = phase_i[PHASE_BITS-1:FB];
  assign idx_n  = idx + 1'b1;
  assign tri_w  = phase_i[PHASE_BITS-1] ?
                  ((PHASE_BITS+2)'(1) << (PHASE_BITS+1)) - {1'b0, phase_i, 1'b0} :
                  {1'b0, phase_i, 1'b0};
  assign down_w = {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, phase_i};

  always_comb begin
    case (cfg_i.waveform)
      tsl_pkg::WAVE_TRIANGLE:  u_other = UW'(tri_w >> SH);
      tsl_pkg::WAVE_RAMP_UP:   u_other = UW'(phase_i >> SH);
      tsl_pkg::WAVE_RAMP_DOWN: u_other = UW'(down_w >> SH);
      tsl_pkg::WAVE_SQUARE:    u_other = phase_i[PHASE_BITS-1] ? tsl_pkg::UNIT_ONE : '0;
      default:                 u_other = '0;
    endcase
  end

  // stage 1: table lookup
  logic          v1_q;
  logic [UW-1:0] e0_q;
  logic [UW-1:0] e1_q;
  logic [FB-1:0] f1_q;
  logic [UW-1:0] uo1_q;
  logic          cos1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e0_q   <= rom[idx];
      e1_q   <= rom[idx_n];
      f1_q   <= phase_i[FB-1:0];
      uo1_q  <= u_other;
      cos1_q <= cfg_i.waveform == tsl_pkg::WAVE_COSINE;
    end
  end

  // stage 2: interpolation weights
  logic [FB:0]      wmf;
  logic             v2_q;
  logic [UW+FB:0]   pa_q;
  logic [UW+FB:0]   pb_q;
  logic [UW-1:0]    uo2_q;
  logic             cos2_q;

  assign wmf = {1'b1, {FB{1'b0}}} - {1'b0, f1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pa_q   <= (UW+FB+1)'(e0_q * wmf);
      pb_q   <= (UW+FB+1)'(e1_q * {1'b0, f1_q});
      uo2_q  <= uo1_q;
      cos2_q <= cos1_q;
    end
  end

  // stage 3: sum and round half up, or pass the non-cosine shape
  logic [UW+FB+1:0] sum;
  logic             v3_q;
  logic [UW-1:0]    u3_q;

  assign sum = {1'b0, pa_q} + {1'b0, pb_q} + ((UW+FB+2)'(1) << (FB - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      u3_q <= cos2_q ? sum[FB+UW-1:FB] : uo2_q;
    end
  end

  assign valid_o = v3_q;
  assign unit_o  = u3_q;

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> u3_q <= tsl_pkg::UNIT_ONE)
    else $error("unit value above one");

endmodule

// ----- rtl/tsl_scale.sv -----
module tsl_scale (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  tsl_pkg::cfg_t                    cfg_i,
  input  logic                             valid_i,
  input  logic [tsl_pkg::UNIT_W-1:0]       unit_i,
  output logic                             valid_o,
  output logic signed [tsl_pkg::OUT_W-1:0] lfo_out_o,
  output logic                             saturated_o
);

  localparam logic signed [26:0] OUT_MAX = 27'sd8388607;
  localparam logic signed [26:0] OUT_MIN = -27'sd8388608;

  logic signed [18:0] a_bi;
  logic signed [18:0] a_uni;
  logic signed [17:0] fac;

  assign a_bi  = $signed({1'b0, unit_i, 1'b0}) - 19'sd65536;
  assign a_uni = $signed({2'b0, unit_i}) - 19'sd32768;
  assign fac   = cfg_i.bipolar ? a_bi[17:0] : a_uni[17:0];

  // stage 1: depth product
  logic               v1_q;
  logic signed [41:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= fac * cfg_i.depth;
    end
  end

  // stage 2: round, offset, clip
  logic signed [41:0] rnd;
  logic signed [25:0] y;
  logic signed [23:0] base;
  logic signed [26:0] v;

  assign rnd  = prod_q + 42'sd32768;
  assign y    = rnd[41:16];
  assign base = cfg_i.bipolar ? 24'sd0 : cfg_i.centre;
  assign v    = {y[25], y} + {{3{base[23]}}, base};

  logic                             v2_q;
  logic signed [tsl_pkg::OUT_W-1:0] out_q;
  logic                             sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (v > OUT_MAX) begin
        out_q <= OUT_MAX[23:0];
        sat_q <= 1'b1;
      end else if (v < OUT_MIN) begin
        out_q <= OUT_MIN[23:0];
        sat_q <= 1'b1;
      end else begin
        out_q <= v[23:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign valid_o     = v2_q;
  assign lfo_out_o   = out_q;
  assign saturated_o = sat_q;

  a_sat_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && sat_q |-> out_q == OUT_MAX[23:0] || out_q == OUT_MIN[23:0])
    else $error("saturated flag without clipped value");

endmodule

// ----- dv/tempo_synced_lfo_tb.sv -----
`timescale 1ns / 1ps

module tempo_synced_lfo_tb;

  localparam int SINE_BITS  = 10;
  localparam int PH_BITS    = 24;
  localparam int LATENCY    = 56 + PH_BITS;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [tsl_pkg::OUT_W-1:0] lfo_out;
    logic                             saturated;
  } lfo_res_t;

  class lfo_scoreboard;
    lfo_res_t pending[$];
    int       errors;

    function void note_input(lfo_res_t r);
      pending = {pending, r};
    endfunction

    function void check_result(lfo_res_t got);
      lfo_res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result lfo_out=%0d saturated=%0b", $time,
                 got.lfo_out, got.saturated);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want.lfo_out !== got.lfo_out) begin
        $display("%0t: lfo_out expected %0d actual %0d", $time, want.lfo_out, got.lfo_out);
        errors++;
      end
      if (want.saturated !== got.saturated) begin
        $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                 got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tsl_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [tsl_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  tsl_in_if  in_ch();
  tsl_out_if out_ch();

  tempo_synced_lfo u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch.sink),
    .out_o     (out_ch.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lfo_scoreboard sb = new();
  tsl_pkg::cfg_t shadow;
  logic [16:0] sine_sq[0:(1<<SINE_BITS)-1];
  bit   calm;
  bit   out_stall_en;
  longint cycles;

  // sin^2 table, built independently from a series evaluation in q30
  function automatic logic [16:0] sq_entry(int k);
    longint unsigned m, th, t2, a, s, u;
    longint unsigned n;
    n  = 64'd1 << SINE_BITS;
    m  = (k > n / 2) ? n - k : k;
    th = (64'd3373259426 * m) >> SINE_BITS;
    t2 = (th * th) >> 30;
    a  = (64'd1 << 30) - t2 / 110;
    a  = (64'd1 << 30) - ((t2 * a) >> 30) / 72;
    a  = (64'd1 << 30) - ((t2 * a) >> 30) / 42;
    a  = (64'd1 << 30) - ((t2 * a) >> 30) / 20;
    a  = (64'd1 << 30) - ((t2 * a) >> 30) / 6;
    s  = (th * a) >> 30;
    u  = (s * s + (64'd1 << 43)) >> 44;
    return (u > 65536) ? 17'd65536 : u[16:0];
  endfunction

  function automatic longint scale_round(longint x);
    longint y;
    y = x + 32768;
    if (y >= 0) return y >>> 16;
    return -(((-y) + 65535) >>> 16);
  endfunction

  function automatic lfo_res_t predict_lfo(logic [47:0] ts, logic signed [47:0] beat);
    longint unsigned frac, p, u, full, f, w, idx;
    longint b, r, v;
    lfo_res_t res;
    full = 64'd1 << PH_BITS;
    if (shadow.beats != 0) begin
      b = longint'({32'd0, shadow.beats});
      r = longint'(beat) % b;
      if (r < 0) r += b;
      frac = (longint'(r) << PH_BITS) / b;
    end else begin
      frac = ((64'(ts) * 64'(shadow.rate)) & 64'hFFFF_FFFF) >> (32 - PH_BITS);
    end
    p = (frac + 64'(shadow.offset)) & (full - 1);
    case (shadow.waveform)
      tsl_pkg::WAVE_COSINE: begin
        w   = 64'd1 << (PH_BITS - SINE_BITS);
        idx = p >> (PH_BITS - SINE_BITS);
        f   = p & (w - 1);
        u   = (64'(sine_sq[idx % (1 << SINE_BITS)]) * (w - f) +
               64'(sine_sq[(idx + 1) % (1 << SINE_BITS)]) * f + (w >> 1))
              >> (PH_BITS - SINE_BITS);
      end
      tsl_pkg::WAVE_TRIANGLE: u = (p < full / 2) ? (2 * p) >> (PH_BITS - 16)
                                                 : (2 * full - 2 * p) >> (PH_BITS - 16);
      tsl_pkg::WAVE_RAMP_UP:   u = p >> (PH_BITS - 16);
      tsl_pkg::WAVE_RAMP_DOWN: u = (full - p) >> (PH_BITS - 16);
      tsl_pkg::WAVE_SQUARE:    u = (p < full / 2) ? 0 : 65536;
      default:                 u = 0;
    endcase
    if (shadow.bipolar)
      v = scale_round((longint'(2 * u) - 65536) * longint'(shadow.depth));
    else
      v = longint'(shadow.centre) + scale_round((longint'(u) - 32768) * longint'(shadow.depth));
    res.saturated = 1'b0;
    if (v > 8388607) begin
      v = 8388607;
      res.saturated = 1'b1;
    end
    if (v < -8388608) begin
      v = -8388608;
      res.saturated = 1'b1;
    end
    res.lfo_out = v[23:0];
    return res;
  endfunction

  // drop valid and hold off until every expected result is back
  task automatic wait_empty();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [tsl_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    wait_empty();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tsl_pkg::REG_WAVEFORM: shadow.waveform = data[2:0];
      tsl_pkg::REG_BIPOLAR:  shadow.bipolar  = data[0];
      tsl_pkg::REG_DEPTH:    shadow.depth    = data[23:0];
      tsl_pkg::REG_CENTRE:   shadow.centre   = data[23:0];
      tsl_pkg::REG_RATE:     shadow.rate     = data;
      tsl_pkg::REG_BEATS:    shadow.beats    = data;
      tsl_pkg::REG_OFFSET:   shadow.offset   = data[23:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain();
    wait_empty();
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic send_item(logic [47:0] ts, logic [47:0] beat);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.time_stamp <= ts;
    in_ch.beat_pos   <= beat;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(predict_lfo(ts, beat));
    @(negedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()} >> 16);
  endfunction

  task automatic random_config(bit extreme);
    int sel;
    write_reg(tsl_pkg::REG_WAVEFORM, $urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                               : $urandom_range(0, 4));
    write_reg(tsl_pkg::REG_BIPOLAR, $urandom_range(0, 1));
    sel = $urandom_range(0, 3);
    write_reg(tsl_pkg::REG_DEPTH, extreme ? (sel[0] ? 32'h7FFFFF : 32'h800000)
                                          : (sel == 0 ? $urandom() : $urandom_range(0, 131072)));
    write_reg(tsl_pkg::REG_CENTRE, extreme ? (sel[1] ? 32'h7FFFFF : 32'h800000)
                                           : (sel == 1 ? $urandom() : $urandom_range(0, 65536)));
    write_reg(tsl_pkg::REG_RATE, $urandom_range(0, 3) == 0 ? $urandom()
                                                           : $urandom_range(0, 1 << 20));
    case ($urandom_range(0, 3))
      0: write_reg(tsl_pkg::REG_BEATS, 32'd0);
      1: write_reg(tsl_pkg::REG_BEATS, $urandom());
      2: write_reg(tsl_pkg::REG_BEATS, 32'hFFFF_FFFF);
      default: write_reg(tsl_pkg::REG_BEATS, $urandom_range(1, 1 << 20));
    endcase
    write_reg(tsl_pkg::REG_OFFSET, $urandom());
  endtask

  // result side: random stall bursts
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && out_stall_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result('{lfo_out: out_ch.lfo_out, saturated: out_ch.saturated});

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [47:0] ts;
    logic [47:0] bp;
    for (int k = 0; k < (1 << SINE_BITS); k++) sine_sq[k] = sq_entry(k);
    in_ch.valid = 1'b0;
    in_ch.time_stamp = '0;
    in_ch.beat_pos = '0;
    calm = 1'b0;
    out_stall_en = 1'b1;
    cycles = 0;
    shadow = '{waveform: tsl_pkg::WAVE_COSINE, bipolar: 1'b0, depth: 24'sd65536,
               centre: 24'sd32768, rate: 32'd65536, beats: 32'd0, offset: 24'd0};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes at the reset defaults, then every shape
    send_item('0, '0);
    send_item(48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
    send_item(48'h0000_0000_8000, 48'h8000_0000_0000);
    for (int wv = 0; wv < 6; wv++) begin
      write_reg(tsl_pkg::REG_WAVEFORM, wv);
      write_reg(tsl_pkg::REG_BIPOLAR, 32'(wv[0]));
      send_item(48'h0000_0000_4000, 48'hFFFF_FFFF_FFFF);
      send_item(48'h0000_0001_C000, 48'h0);
    end
    drain();
    // saturation, zero rate, beat sync going backwards
    write_reg(tsl_pkg::REG_WAVEFORM, 32'(tsl_pkg::WAVE_SQUARE));
    write_reg(tsl_pkg::REG_BIPOLAR, 32'd1);
    write_reg(tsl_pkg::REG_DEPTH, 32'h7FFFFF);
    write_reg(tsl_pkg::REG_RATE, 32'd0);
    write_reg(tsl_pkg::REG_OFFSET, 32'h0090_0000);
    send_item(48'h1234_5678_9ABC, '0);
    write_reg(tsl_pkg::REG_BIPOLAR, 32'd0);
    write_reg(tsl_pkg::REG_CENTRE, 32'h800000);
    write_reg(tsl_pkg::REG_DEPTH, 32'h800000);
    send_item('0, '0);
    write_reg(tsl_pkg::REG_BEATS, 32'h0004_0000);
    write_reg(tsl_pkg::REG_WAVEFORM, 32'(tsl_pkg::WAVE_RAMP_UP));
    send_item('0, 48'hFFFF_FFFF_0000);
    send_item('0, 48'hFFFF_FFFE_8000);
    send_item('0, 48'h8000_0000_0000);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      random_config(ph < 2);
      if (ph == 9) calm = 1'b1;
      for (int i = 0; i < 45; i++) begin
        ts = rand48();
        bp = rand48();
        if ($urandom_range(0, 7) == 0) begin
          ts = $urandom_range(0, 1) ? '0 : '1;
          bp = $urandom_range(0, 1) ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        end
        send_item(ts, bp);
        // hold off until everything is back once
        if (ph == 4 && i == 20) begin
          wait_empty();
          @(negedge clk_i);
        end
      end
      drain();
    end

    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
